@@ design/brs_pkg.sv @@
// ----------------------------------------------------------------------------
// brs_pkg: shared types and constants for the bitmap run-to-span converter
// Holds the configuration bundle, the span job passed from front to back,
// register indexes and the edge-search helpers.
// ----------------------------------------------------------------------------
package brs_pkg;

    localparam int WORD_BITS = 32;
    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = 7;    // word column within a row
    localparam int POS_W     = 12;   // pixel column
    localparam int WID_W     = 13;   // row width and span width
    localparam int COORD_W   = 16;   // destination coordinates
    localparam int EDGE_W    = WORD_BITS + 1;  // edge slots incl. row close
    localparam int EIDX_W    = 6;    // index into edge slots
    localparam int BIDX_W    = 5;    // index into word bits
    localparam int CNT_W     = 6;    // used pixels in one word, 0..32

    typedef enum logic [1:0] {
        REG_ROW_WIDTH = 2'd0,
        REG_ORIGIN_X  = 2'd1,
        REG_ORIGIN_Y  = 2'd2,
        REG_MSB_FIRST = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [WID_W-1:0]   row_width;
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic               msb_first;
    } t_cfg;

    // One word's worth of span work: falling edges close runs, rising
    // edges open them; carry says a run was already open at the word start.
    typedef struct packed {
        logic [EDGE_W-1:0]    fall;
        logic [WORD_BITS-1:0] rise;
        logic                 carry;
        logic [POS_W-1:0]     carry_start;
        logic [POS_W-1:0]     base;
        logic [COORD_W-1:0]   row;
    } t_span_job;

    // Lowest set bit of the edge vector.
    function automatic logic [EIDX_W-1:0] first_edge(input logic [EDGE_W-1:0] v);
        logic [EIDX_W-1:0] idx;
        idx = '0;
        for (int i = EDGE_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = EIDX_W'(i);
            end
        end
        return idx;
    endfunction

    // Lowest set bit of a word.
    function automatic logic [BIDX_W-1:0] first_bit(input logic [WORD_BITS-1:0] v);
        logic [BIDX_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIDX_W'(i);
            end
        end
        return idx;
    endfunction

    // Highest set bit of a word.
    function automatic logic [BIDX_W-1:0] last_bit(input logic [WORD_BITS-1:0] v);
        logic [BIDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (v[i]) begin
                idx = BIDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ design/brs_front.sv @@
// ----------------------------------------------------------------------------
// brs_front: word intake and edge classification
// Puts the word in pixel order, masks pixels past the row end, finds run
// edges, tracks row position and open-run state, and pushes span jobs.
// ----------------------------------------------------------------------------
module brs_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [31:0]                 i_bitmap_word,
    input  logic                        i_final_word,
    input  brs_pkg::t_cfg               i_cfg,
    input  logic                        i_q_full,
    output logic                        o_push,
    output brs_pkg::t_span_job          o_job
);
    import brs_pkg::*;

    logic [COL_W-1:0]     r_word_column;
    logic [COORD_W-1:0]   r_row_index;
    logic                 r_in_run;
    logic [POS_W-1:0]     r_run_start;

    logic [WID_W-1:0]     eff_width;
    logic [WID_W-1:0]     remain;
    logic [POS_W-1:0]     base;
    logic [CNT_W-1:0]     used;
    logic                 row_end;
    logic [WORD_BITS-1:0] pix;
    logic [EDGE_W-1:0]    prev;
    logic [EDGE_W-1:0]    fall;
    logic [WORD_BITS-1:0] rise;
    logic                 accept;

    always_comb begin
        eff_width = i_cfg.row_width;
        if (eff_width == '0) begin
            eff_width = WID_W'(1);
        end else if (eff_width > WID_W'(MAX_WIDTH)) begin
            eff_width = WID_W'(MAX_WIDTH);
        end
        base   = {r_word_column, BIDX_W'(0)};
        remain = eff_width - {1'b0, base};
        if ({1'b0, base} >= eff_width) begin
            used    = '0;
            row_end = 1'b1;
        end else if (remain <= WID_W'(WORD_BITS)) begin
            used    = remain[CNT_W-1:0];
            row_end = 1'b1;
        end else begin
            used    = CNT_W'(WORD_BITS);
            row_end = 1'b0;
        end
        row_end = row_end | i_final_word;

        for (int i = 0; i < WORD_BITS; i++) begin
            pix[i] = (i_cfg.msb_first ? i_bitmap_word[WORD_BITS-1-i] : i_bitmap_word[i])
                     & (CNT_W'(i) < used);
        end
        // Slot past the last pixel closes a run only at a row end.
        prev = {pix, r_in_run};
        fall = prev & ~{1'b0, pix};
        fall[EDGE_W-1] = fall[EDGE_W-1] & row_end;
        rise = pix & ~prev[WORD_BITS-1:0];
    end

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (fall != '0);

    always_comb begin
        o_job.fall        = fall;
        o_job.rise        = rise;
        o_job.carry       = r_in_run;
        o_job.carry_start = r_run_start;
        o_job.base        = base;
        o_job.row         = r_row_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_column <= '0;
            r_row_index   <= '0;
            r_in_run      <= 1'b0;
            r_run_start   <= '0;
        end else if (accept) begin
            if (row_end) begin
                r_word_column <= '0;
                r_in_run      <= 1'b0;
                r_row_index   <= i_final_word ? '0 : r_row_index + COORD_W'(1);
            end else begin
                r_word_column <= r_word_column + COL_W'(1);
                r_in_run      <= pix[WORD_BITS-1];
                if (rise != '0) begin
                    r_run_start <= base + POS_W'(last_bit(rise));
                end
            end
        end
    end

endmodule

@@ design/brs_queue.sv @@
// ----------------------------------------------------------------------------
// brs_queue: span job queue
// Small first-in first-out buffer that lets front and back stall apart.
// ----------------------------------------------------------------------------
module brs_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  brs_pkg::t_span_job  i_job,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_pop,
    output brs_pkg::t_span_job  o_job
);
    import brs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    t_span_job          r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_QW-1:0]  r_count;

    assign o_full  = (r_count == CNT_QW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_QW'(1);
                2'b01:   r_count <= r_count - CNT_QW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ design/brs_back.sv @@
// ----------------------------------------------------------------------------
// brs_back: span drain
// Takes one job at a time and emits one span per cycle into the output
// register while the receiver keeps up, lowest closing edge first.
// ----------------------------------------------------------------------------
module brs_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  brs_pkg::t_span_job          i_job,
    output logic                        o_pop,
    input  brs_pkg::t_cfg               i_cfg,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [15:0]          o_span_x,
    output logic signed [15:0]          o_span_y,
    output logic [12:0]                 o_span_width,
    output logic                        o_last_span
);
    import brs_pkg::*;

    logic                 r_w_valid;
    logic [EDGE_W-1:0]    r_fall;
    logic [WORD_BITS-1:0] r_rise;
    logic                 r_carry;
    logic [POS_W-1:0]     r_carry_start;
    logic [POS_W-1:0]     r_base;
    logic [COORD_W-1:0]   r_row;

    logic                 r_out_valid;
    logic [COORD_W-1:0]   r_span_x;
    logic [COORD_W-1:0]   r_span_y;
    logic [WID_W-1:0]     r_span_width;
    logic                 r_last_span;

    logic                 out_free;
    logic                 emit;
    logic [EIDX_W-1:0]    end_idx;
    logic [POS_W-1:0]     start_col;
    logic [WID_W-1:0]     end_col;
    logic [EDGE_W-1:0]    n_fall;
    logic [WORD_BITS-1:0] n_rise;
    logic                 last;

    always_comb begin
        end_idx   = first_edge(r_fall);
        start_col = r_carry ? r_carry_start : r_base + POS_W'(first_bit(r_rise));
        end_col   = {1'b0, r_base} + WID_W'(end_idx);
        for (int i = 0; i < EDGE_W; i++) begin
            n_fall[i] = r_fall[i] & (EIDX_W'(i) > end_idx);
        end
        for (int i = 0; i < WORD_BITS; i++) begin
            n_rise[i] = r_rise[i] & (EIDX_W'(i) > end_idx);
        end
        last = (n_fall == '0);
    end

    assign out_free = !r_out_valid || i_ready;
    assign emit     = r_w_valid && out_free;
    assign o_pop    = i_q_valid && (!r_w_valid || (emit && last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
        end else if (o_pop) begin
            r_w_valid <= 1'b1;
        end else if (emit && last) begin
            r_w_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_fall        <= i_job.fall;
            r_rise        <= i_job.rise;
            r_carry       <= i_job.carry;
            r_carry_start <= i_job.carry_start;
            r_base        <= i_job.base;
            r_row         <= i_job.row;
        end else if (emit) begin
            r_fall  <= n_fall;
            r_rise  <= n_rise;
            r_carry <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_span_x     <= i_cfg.origin_x + COORD_W'(start_col);
            r_span_y     <= i_cfg.origin_y + r_row;
            r_span_width <= end_col - {1'b0, start_col};
            r_last_span  <= last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_span_x     = r_span_x;
    assign o_span_y     = r_span_y;
    assign o_span_width = r_span_width;
    assign o_last_span  = r_last_span;

endmodule

@@ design/bitmap_runs_to_spans.sv @@
// ----------------------------------------------------------------------------
// bitmap_runs_to_spans: one-bit stencil bitmap to horizontal spans
// Turns each maximal run of set pixels in a row into one (x, y, width) span.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready): one 32-bit stencil word per request,
//   row by row, ceil(row_width/32) words per row; i_final_word marks the
//   last word of the bitmap and returns the block to row 0, column 0.
//   Output channel (o_valid / i_ready): one span per request; o_last_span
//   marks the last span caused by a word. Words with no run end give none.
//   Configure through the APB-style port only while the block is idle:
//   row_width at 0x0, origin_x at 0x4, origin_y at 0x8, msb_first at 0xC.
//   Throughput: a word is taken every cycle while the job queue has room;
//   the back end drains one span per cycle while the receiver keeps up, so
//   a word holds the back end until all of its spans are out. That drain
//   rate sets the sustained rate. A word's job enters the queue, is popped
//   into the back end, and its first span is registered at the outputs.
//   Reset: row and column clear, no run is open, the queue empties and the
//   registers go to row_width 32, origins 0, msb_first 1.
//   Receiver stall: the output register holds its span, the back end
//   waits, the queue fills and o_ready drops once it is full.
// ----------------------------------------------------------------------------
module bitmap_runs_to_spans #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input words
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_bitmap_word,
    input  logic               i_final_word,
    // output spans
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_span_x,
    output logic signed [15:0] o_span_y,
    output logic [12:0]        o_span_width,
    output logic               o_last_span,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import brs_pkg::*;

    t_cfg       r_cfg;
    t_reg_idx   reg_idx;
    logic       cfg_write;

    logic       q_full;
    logic       q_valid;
    logic       push;
    logic       pop;
    t_span_job  front_job;
    t_span_job  head_job;

    // Registers sit on word addresses; the low address bits are ignored.
    assign reg_idx   = t_reg_idx'(paddr[3:2]);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_width <= WID_W'(32);
            r_cfg.origin_x  <= '0;
            r_cfg.origin_y  <= '0;
            r_cfg.msb_first <= 1'b1;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_ROW_WIDTH: r_cfg.row_width <= pwdata[WID_W-1:0];
                REG_ORIGIN_X:  r_cfg.origin_x  <= pwdata[COORD_W-1:0];
                REG_ORIGIN_Y:  r_cfg.origin_y  <= pwdata[COORD_W-1:0];
                REG_MSB_FIRST: r_cfg.msb_first <= pwdata[0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    // Read back zero-extended.
    always_comb begin
        unique case (reg_idx)
            REG_ROW_WIDTH: prdata = {19'd0, r_cfg.row_width};
            REG_ORIGIN_X:  prdata = {16'd0, r_cfg.origin_x};
            REG_ORIGIN_Y:  prdata = {16'd0, r_cfg.origin_y};
            REG_MSB_FIRST: prdata = {31'd0, r_cfg.msb_first};
            default:       prdata = '0;
        endcase
    end

    // Front end: classify each word into a span job.
    brs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_bitmap_word (i_bitmap_word),
        .i_final_word  (i_final_word),
        .i_cfg         (r_cfg),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (front_job)
    );

    // Decouple intake from span drain.
    brs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (head_job)
    );

    // Back end: one span per cycle into the output register when free.
    brs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_job        (head_job),
        .o_pop        (pop),
        .i_cfg        (r_cfg),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_span_x     (o_span_x),
        .o_span_y     (o_span_y),
        .o_span_width (o_span_width),
        .o_last_span  (o_last_span)
    );

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the bitmap run-to-span converter
// Pushes stencil words through the request channel, rebuilds every span the
// block should emit with a local run tracker, and compares each span taken
// from the output channel against the oldest one still due. A directed table
// opens the run; three randomized phases with changing register settings and
// changing idle patterns on both channels follow.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brs_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int SETTLE      = 16;       // queue depth plus pipeline, with margin
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 120;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [12:0] width;
        logic        last;
    } t_span;

    typedef enum int {FILL_RANDOM, FILL_SPARSE, FILL_DENSE, FILL_SOLID, FILL_STRIPES} t_fill;

    // One row of the directed table: a register write or a stencil word, the
    // latter optionally with up to two spans written out by hand.
    typedef struct packed {
        logic        cfg_write;
        logic [1:0]  idx;
        logic [31:0] data;
        logic        fin;
        logic        known;
        logic [1:0]  n;
        logic [15:0] x0;
        logic [15:0] y0;
        logic [12:0] w0;
        logic [15:0] x1;
        logic [15:0] y1;
        logic [12:0] w1;
    } t_plan_row;

    localparam int PLAN_LEN = 31;
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        // reset settings: 32 pixels per row, leftmost pixel in bit 31
        '{data: 32'hFFFF_FFFF, known: 1'b1, n: 2'd1, w0: 13'd32, default: '0},
        '{data: 32'h0000_0000, known: 1'b1, default: '0},
        '{data: 32'h8000_0001, known: 1'b1, n: 2'd2, y0: 16'd2, w0: 13'd1,
          x1: 16'd31, y1: 16'd2, w1: 13'd1, default: '0},
        '{data: 32'h0000_FFFF, fin: 1'b1, known: 1'b1, n: 2'd1,
          x0: 16'd16, y0: 16'd3, w0: 13'd16, default: '0},
        // leftmost pixel in bit 0
        '{cfg_write: 1'b1, idx: REG_MSB_FIRST, data: 32'd0, default: '0},
        '{data: 32'h0000_0001, known: 1'b1, n: 2'd1, w0: 13'd1, default: '0},
        '{data: 32'hAAAA_AAAA, default: '0},
        '{data: 32'h5555_5555, default: '0},
        // two-word rows: carried run plus alternating pixels gives 17 spans
        '{cfg_write: 1'b1, idx: REG_ROW_WIDTH, data: 32'd64, default: '0},
        '{data: 32'h8000_0000, default: '0},
        '{data: 32'hAAAA_AAAA, default: '0},
        // zero width acts as one pixel per row
        '{cfg_write: 1'b1, idx: REG_ROW_WIDTH, data: 32'd0, default: '0},
        '{data: 32'hFFFF_FFFF, default: '0},
        '{data: 32'hFFFF_FFFE, default: '0},
        // oversized width saturates; final word closes the run mid-row
        '{cfg_write: 1'b1, idx: REG_ROW_WIDTH, data: 32'd8191, default: '0},
        '{data: 32'hFFFF_FFFF, default: '0},
        '{data: 32'hFFFF_FFFF, fin: 1'b1, default: '0},
        // origins at the 16-bit extremes, run wraps its x coordinate
        '{cfg_write: 1'b1, idx: REG_ORIGIN_X, data: 32'h7FFF, default: '0},
        '{cfg_write: 1'b1, idx: REG_ORIGIN_Y, data: 32'h8000, default: '0},
        '{cfg_write: 1'b1, idx: REG_MSB_FIRST, data: 32'd1, default: '0},
        '{cfg_write: 1'b1, idx: REG_ROW_WIDTH, data: 32'd40, default: '0},
        '{data: 32'hFFFF_FFFF, default: '0},
        '{data: 32'hFF00_0000, known: 1'b1, n: 2'd1,
          x0: 16'h7FFF, y0: 16'h8000, w0: 13'd40, default: '0},
        '{data: 32'h0000_0001, default: '0},
        '{data: 32'h0000_0000, known: 1'b1, n: 2'd1,
          x0: 16'h801E, y0: 16'h8001, w0: 13'd1, default: '0},
        // shrink the row under an open run: next word lies past the row end
        '{cfg_write: 1'b1, idx: REG_ORIGIN_X, data: 32'h8000, default: '0},
        '{cfg_write: 1'b1, idx: REG_ROW_WIDTH, data: 32'd64, default: '0},
        '{data: 32'h0000_0001, default: '0},
        '{cfg_write: 1'b1, idx: REG_ROW_WIDTH, data: 32'd32, default: '0},
        '{data: 32'hFFFF_FFFF, known: 1'b1, n: 2'd1,
          x0: 16'h801F, y0: 16'h8002, w0: 13'd1, default: '0},
        '{data: 32'h0000_0000, fin: 1'b1, default: '0}
    };

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic               o_ready;
    logic [31:0]        i_bitmap_word = '0;
    logic               i_final_word  = 1'b0;
    logic               o_valid;
    logic               i_ready       = 1'b0;
    logic signed [15:0] o_span_x;
    logic signed [15:0] o_span_y;
    logic [12:0]        o_span_width;
    logic               o_last_span;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [3:0]         paddr         = '0;
    logic [31:0]        pwdata        = '0;
    logic [31:0]        prdata;
    logic               pready;

    bitmap_runs_to_spans dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_bitmap_word (i_bitmap_word),
        .i_final_word  (i_final_word),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_span_x      (o_span_x),
        .o_span_y      (o_span_y),
        .o_span_width  (o_span_width),
        .o_last_span   (o_last_span),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Run tracker: local copy of the registers and of the row/run state
    // ------------------------------------------------------------------------
    t_cfg        cfg_now = '{row_width: 13'd32, origin_x: '0, origin_y: '0, msb_first: 1'b1};
    logic [6:0]  col_at   = '0;    // word position within the current row
    logic [15:0] row_at   = '0;    // row number, wraps at 16 bits
    logic        run_open = 1'b0;
    logic [11:0] run_from = '0;    // column where the open run began

    t_span fresh[$];       // spans caused by the word just accepted
    t_span spans_due[$];   // spans still owed by the block, oldest first

    int  errors        = 0;
    int  words_sent    = 0;
    int  snd_idle_pct  = 23;
    int  rcv_idle_pct  = 82;
    int  calm_left     = 0;    // cycles left in a stretch with no idling
    bit  long_row_done = 1'b0;

    // Clamp the width register the way the block reads it.
    function automatic int unsigned usable_width();
        if (cfg_now.row_width == 0) return 1;
        if (cfg_now.row_width > MAX_WIDTH) return MAX_WIDTH;
        return 32'(cfg_now.row_width);
    endfunction

    function automatic void close_run(input int unsigned end_col);
        t_span sp;
        sp.x     = cfg_now.origin_x + 16'(run_from);
        sp.y     = cfg_now.origin_y + row_at;
        sp.width = 13'(end_col - run_from);
        sp.last  = 1'b0;
        fresh.push_back(sp);
    endfunction

    // Walk the used pixels of one word left to right, open and close runs,
    // then close the row if the word ends it.
    function automatic void trace_word(input logic [31:0] w, input logic fin);
        int unsigned wid;
        int unsigned base;
        int unsigned used;
        logic        row_done;
        logic        pix;
        fresh.delete();
        wid  = usable_width();
        base = col_at * WORD_BITS;
        if (base >= wid) begin
            used     = 0;      // word lies past the row end
            row_done = 1'b1;
        end else if (wid - base <= WORD_BITS) begin
            used     = wid - base;
            row_done = 1'b1;
        end else begin
            used     = WORD_BITS;
            row_done = 1'b0;
        end
        row_done |= fin;
        for (int unsigned b = 0; b < used; b++) begin
            pix = cfg_now.msb_first ? w[31 - b] : w[b];
            if (pix) begin
                if (!run_open) begin
                    run_from = 12'(base + b);
                    run_open = 1'b1;
                end
            end else if (run_open) begin
                close_run(base + b);
                run_open = 1'b0;
            end
        end
        if (row_done) begin
            if (run_open) close_run(base + used);
            run_open = 1'b0;
            col_at   = '0;
            row_at   = fin ? 16'd0 : row_at + 16'd1;
        end else begin
            col_at = col_at + 7'd1;
        end
        if (fresh.size() != 0) fresh[fresh.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side: random stalls, broken by calm stretches
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (calm_left != 0) begin
            calm_left <= calm_left - 1;
        end else if ($urandom_range(149) == 0) begin
            calm_left <= $urandom_range(20, 60);
        end
        i_ready <= (calm_left != 0) || ($urandom_range(99) >= rcv_idle_pct);
    end

    // Compare every span taken against the oldest one due.
    always @(posedge i_clk) begin : span_check
        t_span want;
        if (i_rst_n && o_valid && i_ready) begin
            if (spans_due.size() == 0) begin
                $display("%0t unexpected span: expected none, got x=%0d y=%0d width=%0d",
                         $time, o_span_x, o_span_y, o_span_width);
                errors++;
            end else begin
                want = spans_due.pop_front();
                if (o_span_x !== want.x) begin
                    $display("%0t span_x: expected %0d, got %0d",
                             $time, $signed(want.x), o_span_x);
                    errors++;
                end
                if (o_span_y !== want.y) begin
                    $display("%0t span_y: expected %0d, got %0d",
                             $time, $signed(want.y), o_span_y);
                    errors++;
                end
                if (o_span_width !== want.width) begin
                    $display("%0t span_width: expected %0d, got %0d",
                             $time, want.width, o_span_width);
                    errors++;
                end
                if (o_last_span !== want.last) begin
                    $display("%0t last_span: expected %0b, got %0b",
                             $time, want.last, o_last_span);
                    errors++;
                end
            end
        end
    end

    // Abort a hung run.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    function automatic bit sender_rests();
        return (calm_left == 0) && ($urandom_range(99) < snd_idle_pct);
    endfunction

    // Offer one word, hold it until the request completes, then predict.
    // A row with hand-written spans queues those instead of the prediction.
    task automatic send_word(input logic [31:0] w, input logic fin, input logic typed_row);
        if (sender_rests()) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while (sender_rests());
        end
        i_valid       <= 1'b1;
        i_bitmap_word <= w;
        i_final_word  <= fin;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
        trace_word(w, fin);
        if (!typed_row) begin
            foreach (fresh[k]) spans_due.push_back(fresh[k]);
        end
    endtask

    // Drop valid, wait out every due span, then let the pipeline empty.
    task automatic quiesce();
        i_valid <= 1'b0;
        while (spans_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Setup phase, then access phase, then the bus goes idle before returning.
    task automatic reg_write(input t_reg_idx idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ROW_WIDTH: cfg_now.row_width = v[WID_W-1:0];
            REG_ORIGIN_X:  cfg_now.origin_x  = v[COORD_W-1:0];
            REG_ORIGIN_Y:  cfg_now.origin_y  = v[COORD_W-1:0];
            REG_MSB_FIRST: cfg_now.msb_first = v[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // One bitmap under the current settings. Mostly whole rows ending in a
    // final word; sometimes cut short with a final word mid-row, or dropped
    // mid-row with no final word so the next settings find a row half done.
    task automatic send_bitmap();
        int unsigned eff;
        int          per_row;
        int          total;
        int          noise;
        bit          long_row;
        bit          fin_at_end;
        t_fill       style;
        logic [31:0] w;
        eff        = usable_width();
        per_row    = (eff + WORD_BITS - 1) / WORD_BITS;
        style      = t_fill'($urandom_range(4));
        fin_at_end = 1'b1;
        if (per_row > 10) begin
            // walk one full long row once; keep the rest short
            long_row      = !long_row_done;
            long_row_done = 1'b1;
            total         = long_row ? per_row : $urandom_range(1, 6);
        end else begin
            long_row = 1'b0;
            total    = per_row * $urandom_range(1, 4);
        end
        noise = $urandom_range(99);
        if (!long_row && noise < 8) begin
            total = $urandom_range(1, total);
        end else if (!long_row && noise < 14) begin
            total      = $urandom_range(1, total);
            fin_at_end = 1'b0;
        end
        for (int k = 0; k < total; k++) begin
            // hold the sender now and then until the block has caught up
            if ($urandom_range(99) < 2) quiesce();
            case (style)
                FILL_RANDOM: w = $urandom;
                FILL_SPARSE: w = $urandom & $urandom & $urandom;
                FILL_DENSE:  w = $urandom | $urandom | $urandom;
                FILL_SOLID:  w = $urandom_range(1) ? '1 : '0;
                default:     w = $urandom_range(1) ? 32'hAAAA_AAAA : 32'h5555_5555;
            endcase
            if (long_row) w = '1;    // one span across the whole row
            send_word(w, fin_at_end && (k == total - 1), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        t_span       typed;
        int          quota;
        int          pick;
        logic [12:0] rw;
        logic [15:0] ox;
        logic [15:0] oy;
        logic [31:0] junk;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, walked in order with the first idle pattern.
        for (int i = 0; i < PLAN_LEN; i++) begin
            if (PLAN[i].cfg_write) begin
                quiesce();
                reg_write(t_reg_idx'(PLAN[i].idx), PLAN[i].data);
            end else begin
                send_word(PLAN[i].data, PLAN[i].fin, PLAN[i].known);
                for (int k = 0; k < PLAN[i].n; k++) begin
                    typed.x     = (k == 0) ? PLAN[i].x0 : PLAN[i].x1;
                    typed.y     = (k == 0) ? PLAN[i].y0 : PLAN[i].y1;
                    typed.width = (k == 0) ? PLAN[i].w0 : PLAN[i].w1;
                    typed.last  = (k == PLAN[i].n - 1);
                    spans_due.push_back(typed);
                end
            end
        end

        // Random phases: slow receiver, then slow sender, then no idling.
        for (int phase = 0; phase < 3; phase++) begin
            snd_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 82 : 0;
            rcv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 23 : 0;
            quota = words_sent + PHASE_WORDS;
            while (words_sent < quota) begin
                quiesce();
                pick = $urandom_range(99);
                if (pick < 5) begin
                    case ($urandom_range(3))
                        0: rw = 13'd0;
                        1: rw = 13'd1;
                        2: rw = 13'd4096;
                        default: rw = 13'd8191;
                    endcase
                end else if (pick < 10) begin
                    rw = 13'($urandom_range(4064, 8191));
                end else if (pick < 75) begin
                    rw = 13'($urandom_range(1, 96));
                end else begin
                    rw = 13'($urandom_range(97, 320));
                end
                ox = ($urandom_range(99) < 15) ? ($urandom_range(1) ? 16'h8000 : 16'h7FFF)
                                               : 16'($urandom);
                oy = ($urandom_range(99) < 15) ? ($urandom_range(1) ? 16'hFFFF : 16'h7FFF)
                                               : 16'($urandom);
                // upper bus bits carry junk the registers must drop
                junk = $urandom;
                reg_write(REG_ROW_WIDTH, {junk[31:13], rw});
                reg_write(REG_ORIGIN_X,  {junk[31:16], ox});
                reg_write(REG_ORIGIN_Y,  {junk[15:0],  oy});
                reg_write(REG_MSB_FIRST, {junk[31:1],  1'($urandom_range(1))});
                repeat ($urandom_range(1, 3)) send_bitmap();
            end
        end

        // Drain, then give stray spans a chance to show up.
        quiesce();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
